// ===== rtl/core/cdd_pkg.sv =====
// Shared widths, types and register indexes of the contact disc distance block.
package cdd_pkg;

   // Fixed-point widths
   localparam int POS_W   = 32;              // Q16.16 positions
   localparam int UNIT_W  = 16;              // Q1.14 unit components
   localparam int RADIUS_W = 31;             // unsigned Q15.16 radius
   localparam int ORI_W   = 15;              // orientation distance, Q1.14
   localparam int OUT_W   = 40;              // Q24.16 distances
   localparam int CSR_W   = 32;              // config write data
   localparam int CSR_IDX_W = 3;

   // Square root datapath: radicand and root widths
   localparam int ROOT_W  = 36;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 3;

   // Orientation constant: one in Q1.14
   localparam logic [ORI_W-1:0] ONE_Q14 = 15'd16384;

   // Config register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5,
      CSR_RADIUS   = 3'd6
   } csr_index_type;

   // Data that rides along with a radicand through a root pipeline
   typedef struct packed {
      logic [RAD_W-1:0] aux;       // term added after the first root
      logic             op;        // 1: distance to projection point
      logic [ORI_W-1:0] orient;    // orientation distance
   } side_type;

endpackage

// ===== rtl/core/cdd_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit resolved per register stage.
module cdd_sqrt_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [cdd_pkg::RAD_W-1:0]   in_rad,
   input  cdd_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [cdd_pkg::ROOT_W-1:0]  out_root,
   output cdd_pkg::side_type           out_side
);

   localparam int N = cdd_pkg::ROOT_W;

   logic                        vld_ff  [N];
   logic [cdd_pkg::REM_W-1:0]   rem_ff  [N];
   logic [cdd_pkg::ROOT_W-1:0]  root_ff [N];
   logic [cdd_pkg::RAD_W-1:0]   rad_ff  [N];
   cdd_pkg::side_type           side_ff [N];

   logic                        vld_in  [N];
   logic [cdd_pkg::REM_W-1:0]   rem_in  [N];
   logic [cdd_pkg::ROOT_W-1:0]  root_in [N];
   logic [cdd_pkg::RAD_W-1:0]   rad_in  [N];
   cdd_pkg::side_type           side_in [N];

   // One restoring step per stage: bring down two radicand bits, try root*4+1
   always_comb begin
      logic [cdd_pkg::REM_W-1:0]  cur_rem;
      logic [cdd_pkg::ROOT_W-1:0] cur_root;
      logic [cdd_pkg::RAD_W-1:0]  cur_rad;
      logic [cdd_pkg::REM_W-1:0]  rem_sh;
      logic [cdd_pkg::REM_W-1:0]  trial;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            vld_in[i]  = in_valid;
            side_in[i] = in_side;
            cur_rem    = '0;
            cur_root   = '0;
            cur_rad    = in_rad;
         end else begin
            vld_in[i]  = vld_ff[i-1];
            side_in[i] = side_ff[i-1];
            cur_rem    = rem_ff[i-1];
            cur_root   = root_ff[i-1];
            cur_rad    = rad_ff[i-1];
         end
         rem_sh = {cur_rem[cdd_pkg::REM_W-3:0], cur_rad[cdd_pkg::RAD_W-1 -: 2]};
         trial  = {1'b0, cur_root, 2'b01};
         if (rem_sh >= trial) begin
            rem_in[i]  = rem_sh - trial;
            root_in[i] = {cur_root[cdd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_sh;
            root_in[i] = {cur_root[cdd_pkg::ROOT_W-2:0], 1'b0};
         end
         rad_in[i] = {cur_rad[cdd_pkg::RAD_W-3:0], 2'b00};
      end
   end

   // Stage registers; only valid bits are reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         rad_ff[i]  <= rad_in[i];
         side_ff[i] <= side_in[i];
      end
      if (reset) begin
         for (int i = 0; i < N; i++) vld_ff[i] <= 1'b0;
      end else begin
         for (int i = 0; i < N; i++) vld_ff[i] <= vld_in[i];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ===== rtl/core/cdd_front.sv =====
// Front pipeline: offsets, squares, normal offset and orientation distance.
module cdd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic                                opcode,
   input  logic signed [cdd_pkg::POS_W-1:0]    contact_x,
   input  logic signed [cdd_pkg::POS_W-1:0]    contact_y,
   input  logic signed [cdd_pkg::POS_W-1:0]    contact_z,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   quat_w,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   quat_x,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   quat_y,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   quat_z,
   input  logic signed [cdd_pkg::POS_W-1:0]    proj_x,
   input  logic signed [cdd_pkg::POS_W-1:0]    proj_y,
   input  logic signed [cdd_pkg::POS_W-1:0]    proj_z,
   input  logic signed [cdd_pkg::POS_W-1:0]    center_x,
   input  logic signed [cdd_pkg::POS_W-1:0]    center_y,
   input  logic signed [cdd_pkg::POS_W-1:0]    center_z,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   normal_x,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   normal_y,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   normal_z,
   output logic                                out_valid,
   output logic [cdd_pkg::RAD_W-1:0]           out_rad,
   output cdd_pkg::side_type                   out_side
);

   logic signed [cdd_pkg::UNIT_W-1:0] nvec [3];

   // Stage 1: offset vector and quaternion products
   logic              vld1_ff, op1_ff;
   logic signed [32:0] d_ff [3];
   logic signed [31:0] pxz_ff, pwy_ff, pyz_ff, pwx_ff, pxx_ff, pyy_ff;
   // Stage 2: squares, normal projections, contact normal
   logic              vld2_ff, op2_ff;
   logic [65:0]        sq_ff [3];
   logic signed [48:0] dn_ff [3];
   logic signed [34:0] m_ff  [3];
   // Stage 3: sum of squares, rounded normal offset, orientation products
   logic              vld3_ff, op3_ff;
   logic [67:0]        sumsq_ff;
   logic [35:0]        z_ff;
   logic signed [50:0] mn_ff [3];
   // Stage 4: squared normal offset, orientation distance
   logic              vld4_ff, op4_ff;
   logic [67:0]        sumsq4_ff;
   logic [71:0]        z2_ff;
   logic [cdd_pkg::ORI_W-1:0] orient4_ff;
   // Stage 5: first radicand
   logic              vld5_ff;
   logic [cdd_pkg::RAD_W-1:0] rad5_ff;
   cdd_pkg::side_type  side5_ff;

   logic signed [32:0] d_in [3];
   logic [65:0]        sq_in [3];
   logic [50:0]        dot_sum, dot_mag, z_rnd;
   logic [52:0]        odot_sum, odot_mag, a_rnd;
   logic [24:0]        a_val;
   logic [67:0]        sumsq_in;

   assign nvec[0] = normal_x;
   assign nvec[1] = normal_y;
   assign nvec[2] = normal_z;

   // Offset: from the center for the disc, from the projection point otherwise
   always_comb begin
      if (opcode) begin
         d_in[0] = 33'(contact_x) - 33'(proj_x);
         d_in[1] = 33'(contact_y) - 33'(proj_y);
         d_in[2] = 33'(contact_z) - 33'(proj_z);
      end else begin
         d_in[0] = 33'(contact_x) - 33'(center_x);
         d_in[1] = 33'(contact_y) - 33'(center_y);
         d_in[2] = 33'(contact_z) - 33'(center_z);
      end
   end

   // Squares of the offset magnitudes
   always_comb begin
      logic [32:0] mag;
      for (int k = 0; k < 3; k++) begin
         mag      = d_ff[k][32] ? 33'(-d_ff[k]) : 33'(d_ff[k]);
         sq_in[k] = 66'(mag) * 66'(mag);
      end
   end

   // Rounded normal offset |d.n| in Q16.16
   always_comb begin
      dot_sum = 51'(dn_ff[0]) + 51'(dn_ff[1]) + 51'(dn_ff[2]);
      dot_mag = dot_sum[50] ? 51'(-$signed(dot_sum)) : dot_sum;
      z_rnd   = (dot_mag + 51'd8192) >> 14;
      sumsq_in = 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]);
   end

   // Rounded |region normal . contact normal| in Q1.14
   always_comb begin
      odot_sum = 53'(mn_ff[0]) + 53'(mn_ff[1]) + 53'(mn_ff[2]);
      odot_mag = odot_sum[52] ? 53'(-$signed(odot_sum)) : odot_sum;
      a_rnd    = (odot_mag + 53'd134217728) >> 28;
      a_val    = a_rnd[24:0];
   end

   always_ff @(posedge clock) begin
      // stage 1
      op1_ff <= opcode;
      for (int k = 0; k < 3; k++) d_ff[k] <= d_in[k];
      pxz_ff <= 32'(quat_x) * 32'(quat_z);
      pwy_ff <= 32'(quat_w) * 32'(quat_y);
      pyz_ff <= 32'(quat_y) * 32'(quat_z);
      pwx_ff <= 32'(quat_w) * 32'(quat_x);
      pxx_ff <= 32'(quat_x) * 32'(quat_x);
      pyy_ff <= 32'(quat_y) * 32'(quat_y);
      // stage 2
      op2_ff <= op1_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k];
         dn_ff[k] <= 49'(d_ff[k]) * 49'(nvec[k]);
      end
      m_ff[0] <= 35'sd0 - ((35'(pxz_ff) + 35'(pwy_ff)) <<< 1);
      m_ff[1] <= 35'sd0 - ((35'(pyz_ff) - 35'(pwx_ff)) <<< 1);
      m_ff[2] <= ((35'(pxx_ff) + 35'(pyy_ff)) <<< 1) - 35'sd268435456;
      // stage 3
      op3_ff   <= op2_ff;
      sumsq_ff <= sumsq_in;
      z_ff     <= z_rnd[35:0];
      for (int k = 0; k < 3; k++) mn_ff[k] <= 51'(m_ff[k]) * 51'(nvec[k]);
      // stage 4
      op4_ff     <= op3_ff;
      sumsq4_ff  <= sumsq_ff;
      z2_ff      <= 72'(z_ff) * 72'(z_ff);
      orient4_ff <= (a_val < 25'(cdd_pkg::ONE_Q14))
                    ? cdd_pkg::ONE_Q14 - a_val[cdd_pkg::ORI_W-1:0] : '0;
      // stage 5: in-plane radicand clamps at zero; projection case feeds the
      // whole squared length to the second root
      if (!op4_ff && (72'(sumsq4_ff) > z2_ff)) begin
         rad5_ff <= 72'(sumsq4_ff) - z2_ff;
      end else begin
         rad5_ff <= '0;
      end
      side5_ff.op     <= op4_ff;
      side5_ff.orient <= orient4_ff;
      side5_ff.aux    <= op4_ff ? 72'(sumsq4_ff) : z2_ff;
      // valid bits
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   assign out_valid = vld5_ff;
   assign out_rad   = rad5_ff;
   assign out_side  = side5_ff;

endmodule

// ===== rtl/core/cdd_excess.sv =====
// Excess over the disc radius and second radicand.
module cdd_excess (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [cdd_pkg::ROOT_W-1:0]          in_planar,
   input  cdd_pkg::side_type                   in_side,
   input  logic [cdd_pkg::RADIUS_W-1:0]        disc_radius,
   output logic                                out_valid,
   output logic [cdd_pkg::RAD_W-1:0]           out_rad,
   output cdd_pkg::side_type                   out_side
);

   logic                        vld1_ff, vld2_ff, vld3_ff;
   logic [cdd_pkg::ROOT_W-1:0]  xy_ff;
   logic [cdd_pkg::RAD_W-1:0]   xy2_ff, rad_ff;
   cdd_pkg::side_type           side1_ff, side2_ff, side3_ff;
   logic [cdd_pkg::ROOT_W-1:0]  radius_ext;

   assign radius_ext = cdd_pkg::ROOT_W'(disc_radius);

   always_ff @(posedge clock) begin
      // in-plane excess; zero for the projection case
      if (!in_side.op && (in_planar > radius_ext)) begin
         xy_ff <= in_planar - radius_ext;
      end else begin
         xy_ff <= '0;
      end
      side1_ff <= in_side;
      // square of the excess
      xy2_ff   <= cdd_pkg::RAD_W'(xy_ff) * cdd_pkg::RAD_W'(xy_ff);
      side2_ff <= side1_ff;
      // add the normal offset squared (or the full squared length)
      rad_ff          <= xy2_ff + side2_ff.aux;
      side3_ff.op     <= side2_ff.op;
      side3_ff.orient <= side2_ff.orient;
      side3_ff.aux    <= '0;
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   assign out_valid = vld3_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side3_ff;

endmodule

// ===== rtl/core/contact_disc_distance.sv =====
// Top level of the contact disc distance scorer: config registers and pipeline.
// Throughput: one request per cycle; busy is low whenever reset is low.
// Depth is set mostly by two 36-stage square root pipelines in series.
// Reset (synchronous, active high) drops all requests in flight and restores
// the config registers; results are never held off by the receiver.
module contact_disc_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_contact_x,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_contact_y,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_contact_z,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   req_quat_w,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   req_quat_x,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   req_quat_y,
   input  logic signed [cdd_pkg::UNIT_W-1:0]   req_quat_z,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_proj_x,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_proj_y,
   input  logic signed [cdd_pkg::POS_W-1:0]    req_proj_z,
   output logic                                rsp_valid,
   output logic [cdd_pkg::OUT_W-1:0]           rsp_total_distance,
   output logic [cdd_pkg::OUT_W-1:0]           rsp_translation_distance,
   output logic [cdd_pkg::ORI_W-1:0]           rsp_orientation_distance,
   input  logic                                csr_write_en,
   input  logic [cdd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cdd_pkg::CSR_W-1:0]           csr_data
);

   localparam int LATENCY = 5 + cdd_pkg::ROOT_W + 3 + cdd_pkg::ROOT_W + 1;

   logic signed [cdd_pkg::POS_W-1:0]   center_x_ff, center_y_ff, center_z_ff;
   logic signed [cdd_pkg::UNIT_W-1:0]  normal_x_ff, normal_y_ff, normal_z_ff;
   logic [cdd_pkg::RADIUS_W-1:0]       radius_ff;

   logic                        req_accept;
   logic                        f_valid, s1_valid, e_valid, s2_valid;
   logic [cdd_pkg::RAD_W-1:0]   f_rad, e_rad;
   logic [cdd_pkg::ROOT_W-1:0]  s1_root, s2_root;
   cdd_pkg::side_type           f_side, s1_side, e_side, s2_side;

   logic                        rsp_valid_ff;
   logic [cdd_pkg::OUT_W-1:0]   total_ff, trans_ff;
   logic [cdd_pkg::ORI_W-1:0]   orient_ff;

   assign busy       = reset;
   assign req_accept = start & ~busy;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         normal_x_ff <= '0;
         normal_y_ff <= '0;
         normal_z_ff <= 16'sd16384;
         radius_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            cdd_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            cdd_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            cdd_pkg::CSR_CENTER_Z: center_z_ff <= csr_data;
            cdd_pkg::CSR_NORMAL_X: normal_x_ff <= csr_data[cdd_pkg::UNIT_W-1:0];
            cdd_pkg::CSR_NORMAL_Y: normal_y_ff <= csr_data[cdd_pkg::UNIT_W-1:0];
            cdd_pkg::CSR_NORMAL_Z: normal_z_ff <= csr_data[cdd_pkg::UNIT_W-1:0];
            cdd_pkg::CSR_RADIUS:   radius_ff   <= csr_data[cdd_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   cdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .opcode    (req_opcode),
      .contact_x (req_contact_x),
      .contact_y (req_contact_y),
      .contact_z (req_contact_z),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .proj_x    (req_proj_x),
      .proj_y    (req_proj_y),
      .proj_z    (req_proj_z),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .normal_x  (normal_x_ff),
      .normal_y  (normal_y_ff),
      .normal_z  (normal_z_ff),
      .out_valid (f_valid),
      .out_rad   (f_rad),
      .out_side  (f_side)
   );

   // In-plane distance
   cdd_sqrt_pipe u_sqrt_planar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_rad    (f_rad),
      .in_side   (f_side),
      .out_valid (s1_valid),
      .out_root  (s1_root),
      .out_side  (s1_side)
   );

   cdd_excess u_excess (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_planar   (s1_root),
      .in_side     (s1_side),
      .disc_radius (radius_ff),
      .out_valid   (e_valid),
      .out_rad     (e_rad),
      .out_side    (e_side)
   );

   // Translation distance
   cdd_sqrt_pipe u_sqrt_trans (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid),
      .in_rad    (e_rad),
      .in_side   (e_side),
      .out_valid (s2_valid),
      .out_root  (s2_root),
      .out_side  (s2_side)
   );

   // Output register: half the orientation in Q.16 is orientation times two
   always_ff @(posedge clock) begin
      trans_ff  <= cdd_pkg::OUT_W'(s2_root);
      total_ff  <= cdd_pkg::OUT_W'(s2_root)
                   + cdd_pkg::OUT_W'({s2_side.orient, 1'b0});
      orient_ff <= s2_side.orient;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_total_distance       = total_ff;
   assign rsp_translation_distance = trans_ff;
   assign rsp_orientation_distance = orient_ff;

   // Every response traces back to a request exactly one latency earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, LATENCY))
      else $error("response without matching request");

   // Total is translation plus half the orientation: the Q1.14 orientation code times two
   a_total_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_distance == rsp_translation_distance
                     + cdd_pkg::OUT_W'({rsp_orientation_distance, 1'b0})))
      else $error("total distance mismatch");

   // Orientation distance never exceeds one
   a_orient_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_orientation_distance <= cdd_pkg::ONE_Q14))
      else $error("orientation distance above one");

endmodule

// ===== sim/contact_disc_distance_checker.sv =====
// Checker for the contact disc distance scorer: tracks config, predicts and compares results.
module contact_disc_distance_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_opcode,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_contact_x,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_contact_y,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_contact_z,
   input  logic signed [cdd_pkg::UNIT_W-1:0]  req_quat_w,
   input  logic signed [cdd_pkg::UNIT_W-1:0]  req_quat_x,
   input  logic signed [cdd_pkg::UNIT_W-1:0]  req_quat_y,
   input  logic signed [cdd_pkg::UNIT_W-1:0]  req_quat_z,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_proj_x,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_proj_y,
   input  logic signed [cdd_pkg::POS_W-1:0]   req_proj_z,
   input  logic                               rsp_valid,
   input  logic [cdd_pkg::OUT_W-1:0]          rsp_total_distance,
   input  logic [cdd_pkg::OUT_W-1:0]          rsp_translation_distance,
   input  logic [cdd_pkg::ORI_W-1:0]          rsp_orientation_distance,
   input  logic                               csr_write_en,
   input  logic [cdd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cdd_pkg::CSR_W-1:0]          csr_data,
   output int                                 fail_count,
   output int                                 distances_pending,
   output int                                 distances_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [cdd_pkg::OUT_W-1:0] total;
      logic [cdd_pkg::OUT_W-1:0] trans;
      logic [cdd_pkg::ORI_W-1:0] orient;
   } distance_type;

   distance_type distance_queue[$];

   // Shadow copy of the region registers
   logic signed [cdd_pkg::POS_W-1:0]  center_x, center_y, center_z;
   logic signed [cdd_pkg::UNIT_W-1:0] normal_x, normal_y, normal_z;
   logic [cdd_pkg::RADIUS_W-1:0]      radius;

   function automatic logic [63:0] floor_root(input logic [127:0] radicand);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= radicand)
            root = cand;
      end
      return root[63:0];
   endfunction

   function automatic logic [127:0] square(input longint v);
      logic [127:0] u;
      u = (v < 0) ? 128'(-v) : 128'(v);
      return u * u;
   endfunction

   function automatic distance_type score_pose();
      distance_type r;
      longint dx, dy, dz, dot, odot, mx, my, mz, qw, qx, qy, qz, nx, ny, nz;
      logic [127:0] zsq, len2, rem, xy;
      logic [63:0] zoff, planar, trans, a, orient;
      nx = normal_x; ny = normal_y; nz = normal_z;
      if (!req_opcode) begin
         dx = longint'(req_contact_x) - longint'(center_x);
         dy = longint'(req_contact_y) - longint'(center_y);
         dz = longint'(req_contact_z) - longint'(center_z);
         dot = dx * nx + dy * ny + dz * nz;
         zoff = ((dot < 0 ? -dot : dot) + 64'd8192) >> 14;
         zsq = 128'(zoff) * 128'(zoff);
         len2 = square(dx) + square(dy) + square(dz);
         // rounding can push the normal offset past the full length
         rem = (len2 <= zsq) ? 128'd0 : len2 - zsq;
         planar = floor_root(rem);
         xy = (planar > 64'(radius)) ? 128'(planar - 64'(radius)) : 128'd0;
         trans = floor_root(xy * xy + zsq);
      end else begin
         trans = floor_root(square(longint'(req_contact_x) - longint'(req_proj_x)) +
                            square(longint'(req_contact_y) - longint'(req_proj_y)) +
                            square(longint'(req_contact_z) - longint'(req_proj_z)));
      end
      // contact normal is the negated third rotation column, Q.28
      qw = req_quat_w; qx = req_quat_x; qy = req_quat_y; qz = req_quat_z;
      mx = -(2 * (qx * qz + qw * qy));
      my = -(2 * (qy * qz - qw * qx));
      mz = -((64'sd1 << 28) - 2 * (qx * qx + qy * qy));
      odot = mx * nx + my * ny + mz * nz;
      a = ((odot < 0 ? -odot : odot) + (64'd1 << 27)) >> 28;
      orient = (a < 64'd16384) ? 64'd16384 - a : 64'd0;
      r.total  = cdd_pkg::OUT_W'(trans + 2 * orient);
      r.trans  = cdd_pkg::OUT_W'(trans);
      r.orient = cdd_pkg::ORI_W'(orient);
      return r;
   endfunction

   always @(posedge clock) begin
      distance_type exp_d;
      if (reset) begin
         center_x <= '0; center_y <= '0; center_z <= '0;
         normal_x <= '0; normal_y <= '0; normal_z <= 16'sd16384;
         radius   <= '0;
         distance_queue.delete();
         fail_count        <= 0;
         distances_seen    <= 0;
         distances_pending <= 0;
      end else begin
         // config writes
         if (csr_write_en) begin
            case (csr_index)
               cdd_pkg::CSR_CENTER_X: center_x <= csr_data;
               cdd_pkg::CSR_CENTER_Y: center_y <= csr_data;
               cdd_pkg::CSR_CENTER_Z: center_z <= csr_data;
               cdd_pkg::CSR_NORMAL_X: normal_x <= csr_data[cdd_pkg::UNIT_W-1:0];
               cdd_pkg::CSR_NORMAL_Y: normal_y <= csr_data[cdd_pkg::UNIT_W-1:0];
               cdd_pkg::CSR_NORMAL_Z: normal_z <= csr_data[cdd_pkg::UNIT_W-1:0];
               cdd_pkg::CSR_RADIUS:   radius   <= csr_data[cdd_pkg::RADIUS_W-1:0];
               default: ;
            endcase
         end
         // accepted request
         if (start && !busy)
            distance_queue.push_back(score_pose());
         // result strobe
         if (rsp_valid) begin
            distances_seen <= distances_seen + 1;
            if (distance_queue.size() == 0) begin
               $display("%0t: unexpected result total=%0d", $time, rsp_total_distance);
               fail_count <= fail_count + 1;
            end else begin
               exp_d = distance_queue.pop_front();
               if (exp_d.total !== rsp_total_distance ||
                   exp_d.trans !== rsp_translation_distance ||
                   exp_d.orient !== rsp_orientation_distance) begin
                  $display("%0t: mismatch expected total=%0d trans=%0d orient=%0d", $time,
                           exp_d.total, exp_d.trans, exp_d.orient);
                  $display("%0t:          actual   total=%0d trans=%0d orient=%0d", $time,
                           rsp_total_distance, rsp_translation_distance,
                           rsp_orientation_distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
         distances_pending <= distance_queue.size();
      end
   end

endmodule

// ===== sim/contact_disc_distance_test.sv =====
// Top of the contact disc distance testbench: clock, reset, stimulus and verdict.
module contact_disc_distance_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cdd_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_PER_PHASE = 240;

   typedef struct {
      logic                       opcode;
      logic [cdd_pkg::POS_W-1:0]  cx, cy, cz;
      logic [cdd_pkg::UNIT_W-1:0] qw, qx, qy, qz;
      logic [cdd_pkg::POS_W-1:0]  px, py, pz;
   } pose_type;

   logic clock = 0, reset = 1, start = 0, csr_write_en = 0;
   logic busy, rsp_valid;
   logic req_opcode = 0;
   logic signed [cdd_pkg::POS_W-1:0]  req_contact_x = 0, req_contact_y = 0, req_contact_z = 0;
   logic signed [cdd_pkg::UNIT_W-1:0] req_quat_w = 0, req_quat_x = 0;
   logic signed [cdd_pkg::UNIT_W-1:0] req_quat_y = 0, req_quat_z = 0;
   logic signed [cdd_pkg::POS_W-1:0]  req_proj_x = 0, req_proj_y = 0, req_proj_z = 0;
   logic [cdd_pkg::OUT_W-1:0] rsp_total_distance, rsp_translation_distance;
   logic [cdd_pkg::ORI_W-1:0] rsp_orientation_distance;
   logic [cdd_pkg::CSR_IDX_W-1:0] csr_index = cdd_pkg::CSR_CENTER_X;
   logic [cdd_pkg::CSR_W-1:0] csr_data = 0;
   int fail_count, distances_pending, distances_seen;
   int burst_left = 0;
   int requests_sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   contact_disc_distance i_dut (.*);

   contact_disc_distance_checker i_checker (.*);

   // drive one request and hold it until accepted; returns on the accepting edge
   task automatic send_pose(input pose_type p);
      logic b;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      start <= 1;
      req_opcode <= p.opcode;
      req_contact_x <= p.cx; req_contact_y <= p.cy; req_contact_z <= p.cz;
      req_quat_w <= p.qw; req_quat_x <= p.qx; req_quat_y <= p.qy; req_quat_z <= p.qz;
      req_proj_x <= p.px; req_proj_y <= p.py; req_proj_z <= p.pz;
      do begin
         @(negedge clock) b = busy;
         @(posedge clock);
      end while (b);
      burst_left--;
      requests_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      start <= 0;
      burst_left = 0;
      @(posedge clock);
      while (distances_pending != 0) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes; csr_done drops it
   task automatic write_csr(input logic [cdd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cdd_pkg::CSR_W-1:0] val);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic csr_done();
      csr_write_en <= 0;
   endtask

   task automatic set_region(input logic [cdd_pkg::POS_W-1:0] x, y, z,
                             input logic [cdd_pkg::UNIT_W-1:0] nx, ny, nz,
                             input logic [cdd_pkg::CSR_W-1:0] rad);
      write_csr(cdd_pkg::CSR_CENTER_X, x);
      write_csr(cdd_pkg::CSR_CENTER_Y, y);
      write_csr(cdd_pkg::CSR_CENTER_Z, z);
      write_csr(cdd_pkg::CSR_NORMAL_X, {{16{nx[15]}}, nx});
      write_csr(cdd_pkg::CSR_NORMAL_Y, {{16{ny[15]}}, ny});
      write_csr(cdd_pkg::CSR_NORMAL_Z, {{16{nz[15]}}, nz});
      write_csr(cdd_pkg::CSR_RADIUS, rad);
   endtask

   function automatic logic [cdd_pkg::POS_W-1:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic logic [cdd_pkg::UNIT_W-1:0] rand_unit();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom);
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      p.opcode = 1'($urandom_range(0, 1));
      p.cx = rand_pos(); p.cy = rand_pos(); p.cz = rand_pos();
      p.qw = rand_unit(); p.qx = rand_unit(); p.qy = rand_unit(); p.qz = rand_unit();
      p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
      return p;
   endfunction

   function automatic pose_type make_pose(input logic op,
                                          input logic [cdd_pkg::POS_W-1:0] c,
                                          input logic [cdd_pkg::UNIT_W-1:0] q0, q1,
                                          input logic [cdd_pkg::POS_W-1:0] pj);
      pose_type p;
      p.opcode = op;
      p.cx = c; p.cy = c; p.cz = c;
      p.qw = q0; p.qx = q1; p.qy = q1; p.qz = q0;
      p.px = pj; p.py = pj; p.pz = pj;
      return p;
   endfunction

   task automatic random_phase();
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         send_pose(rand_pose());
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset region, field extremes, both opcodes
      send_pose(make_pose(0, 32'h7FFF_FFFF, 16'sd16384, 16'sd0, 32'h8000_0000));
      send_pose(make_pose(1, 32'h7FFF_FFFF, 16'sd16384, 16'sd0, 32'h8000_0000));
      send_pose(make_pose(0, 32'h8000_0000, -16'sd16384, 16'sd0, 32'h7FFF_FFFF));
      send_pose(make_pose(1, 32'h8000_0000, 16'sd0, -16'sd16384, 32'h7FFF_FFFF));
      send_pose(make_pose(0, 32'h0, 16'sd0, 16'sd0, 32'h0));
      send_pose(make_pose(1, 32'h0, 16'sd0, 16'sd16384, 32'h0));
      // non-unit quaternions push the dot above one
      send_pose(make_pose(0, 32'h0001_0000, 16'sh8000, 16'sh8000, 32'hFFFF_0000));
      send_pose(make_pose(1, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 32'h1));
      send_pose(make_pose(0, 32'h1234_5678, 16'sd11585, 16'sd11585, 32'h0));
      drain();

      // extreme region: oversized normal forces a negative radicand
      set_region(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 16'sh8000, 16'sh7FFF, -16'sd16384, 32'h7FFF_FFFF);
      write_csr(CSR_UNUSED, $urandom);
      csr_done();
      send_pose(make_pose(0, 32'h0, 16'sd16384, 16'sd0, 32'h0));
      send_pose(make_pose(0, 32'h8000_0000, 16'sd0, 16'sd16384, 32'h0));
      send_pose(make_pose(0, 32'h7FFF_FFFF, 16'sh8000, 16'sh7FFF, 32'h0));
      send_pose(make_pose(1, 32'h8000_0000, 16'sh8000, 16'sh8000, 32'h7FFF_FFFF));
      random_phase();

      set_region(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 16'sd16384, 16'sd16384, 16'sd16384, 32'h0);
      csr_done();
      send_pose(make_pose(0, 32'h0001_0000, 16'sd16384, 16'sd0, 32'h0));
      send_pose(make_pose(0, 32'h8000_0000, 16'sd0, 16'sd0, 32'h0));
      random_phase();

      // region at origin, unit normal along x, modest radius
      set_region(32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 32'h0008_0000);
      csr_done();
      random_phase();

      for (int k = 0; k < 3; k++) begin
         set_region(rand_pos(), rand_pos(), rand_pos(), rand_unit(), rand_unit(),
                    rand_unit(), $urandom_range(0, 1 << 24));
         csr_done();
         random_phase();
      end

      set_region(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd16384, $urandom);
      csr_done();
      random_phase();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over eight region settings, %0d results checked.",
               requests_sent, distances_seen);
      $display("Both opcodes, field extremes, clamped radicand and oversized dot covered.");
      if (fail_count == 0 && distances_pending == 0) begin
         $display("contact_disc_distance_test OK");
      end else begin
         $display("contact_disc_distance_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout waiting for results");
      $display("contact_disc_distance_test NOT OK");
      $finish;
   end

endmodule
